/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top level of the probe drop filter.
// Needs signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent on one edge implies consequent on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/rpdf_pkg.sv */
// Types and constants for the retransmission probe drop filter.
// No dependencies; used by all modules of the block.
package rpdf_pkg;

   localparam int SEQ_W    = 32;
   localparam int CFG_W    = 16;
   localparam int WINDOW_W = 17;
   localparam int CSR_A_W  = 2;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 24;

   localparam logic [CSR_A_W-1:0] REG_ACCEPT_LIMIT  = 2'd0;
   localparam logic [CSR_A_W-1:0] REG_DROP_POSITION = 2'd1;

   localparam logic [CFG_W-1:0] ACCEPT_LIMIT_RST  = 16'd500;
   localparam logic [CFG_W-1:0] DROP_POSITION_RST = 16'd10000;

   typedef enum logic [2:0] {
      CAUSE_MARKER  = 3'd0,
      CAUSE_WINDOW  = 3'd1,
      CAUSE_EMULATE = 3'd2,
      CAUSE_RETRANS = 3'd3,
      CAUSE_TAIL    = 3'd4
   } cause_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // query travelling along the cell row
   typedef struct packed {
      logic             active;
      logic             hit;
      logic [SEQ_W-1:0] seq;
   } link_type;

endpackage

/* hw/rtl/retrans_probe_drop_filter.sv */
// Top level of the retransmission probe drop filter: verdict control,
// counters, result registers. Depends on rpdf_pkg, rpdf_chain, assert_macros.svh.
//
// Use: each word on the req_ channel carries one 32-bit sequence number; each
// produces exactly one verdict word on the rsp_ channel, in order.
// Registers accept_limit (index 0) and drop_position (index 1) are written
// through csr_wen/csr_addr/csr_wdata, other indexes being ignored; the user
// must write them only while the block is idle, which the block does not enforce.
// Marker match and window verdicts: the result reaches rsp_ via the result and
// output registers; a new request can be taken every cycle unless rsp_ stalls.
// Retransmission and tail verdicts: the number walks the row of TABLE_DEPTH
// cells, one cell per cycle, and its result then passes the result and output
// registers to rsp_; no new request is taken before the number has left the row.
// A result register and an output register sit between the verdict logic and
// rsp_, so one request is still taken while a verdict waits for rsp_tready.
// When rsp_tready stays low both fill and req_tready drops until space frees.
// Reset: counters, marker, flags and registers return to their reset values;
// the table needs no clearing, so requests are taken right after reset.
module retrans_probe_drop_filter #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rpdf_pkg::REQ_W-1:0]      req_tdata,  // [31:0] seq_number
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] accept, [3:1] verdict_cause, [4] finished, [21:5] next_window,
   // [22] table_full, [23] zero
   output logic [rpdf_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            csr_wen,
   input  logic [rpdf_pkg::CSR_A_W-1:0]    csr_addr,
   input  logic [rpdf_pkg::CFG_W-1:0]      csr_wdata
);

   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int RES_W = 23;

   rpdf_pkg::state_type              state_ff, state_in;
   logic [rpdf_pkg::CFG_W-1:0]       accept_limit_ff, accept_limit_in;
   logic [rpdf_pkg::CFG_W-1:0]       drop_position_ff, drop_position_in;
   logic [rpdf_pkg::CFG_W-1:0]       accept_count_ff, accept_count_in;
   logic [rpdf_pkg::SEQ_W-1:0]       marker_ff, marker_in;
   logic [CNT_W-1:0]                 drop_count_ff, drop_count_in;
   logic                             finished_ff, finished_in;
   logic [rpdf_pkg::WINDOW_W-1:0]    window_ff, window_in;
   logic                             res_valid_ff, res_valid_in;
   logic [RES_W-1:0]                 res_data_ff, res_data_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rpdf_pkg::RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic [rpdf_pkg::SEQ_W-1:0]       req_seq;
   logic                             req_take;
   logic                             res_move;
   logic                             marker_hit;
   logic                             in_window;
   logic                             table_full;
   logic                             launch;
   logic                             shift_en;
   logic                             verdict_acc;
   rpdf_pkg::cause_type              verdict_cause;
   rpdf_pkg::link_type               head_link;
   rpdf_pkg::link_type               tail_link;

   assign req_seq    = req_tdata[rpdf_pkg::SEQ_W-1:0];
   assign res_move   = res_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == rpdf_pkg::ST_IDLE) && (!res_valid_ff || res_move);
   assign req_take   = req_tvalid && req_tready;
   assign marker_hit = (req_seq == marker_ff);
   assign in_window  = (accept_count_ff < accept_limit_ff);
   assign table_full = (drop_count_ff == CNT_W'(TABLE_DEPTH));

   assign head_link.active = launch;
   assign head_link.hit    = 1'b0;
   assign head_link.seq    = req_seq;

   rpdf_chain #(
      .DEPTH(TABLE_DEPTH),
      .CNT_W(CNT_W)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .head_link  (head_link),
      .head_rem   (drop_count_ff),
      .shift_en   (shift_en),
      .head_entry (tail_link.seq),
      .tail_link  (tail_link)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpdf_pkg::ST_IDLE: begin
            if (req_take && !marker_hit && !in_window) begin
               state_in = rpdf_pkg::ST_SEARCH;
            end
         end
         rpdf_pkg::ST_SEARCH: begin
            if (tail_link.active) begin
               state_in = rpdf_pkg::ST_IDLE;
            end
         end
         default: state_in = rpdf_pkg::ST_IDLE;
      endcase
   end

   // verdicts and state updates
   always_comb begin
      accept_count_in = accept_count_ff;
      marker_in       = marker_ff;
      drop_count_in   = drop_count_ff;
      finished_in     = finished_ff;
      window_in       = window_ff;
      launch          = 1'b0;
      shift_en        = 1'b0;
      verdict_acc     = 1'b0;
      verdict_cause   = rpdf_pkg::CAUSE_TAIL;
      res_valid_in    = res_valid_ff && !res_move;
      case (state_ff)
         rpdf_pkg::ST_IDLE: begin
            if (req_take) begin
               if (marker_hit) begin
                  verdict_acc   = 1'b1;
                  verdict_cause = rpdf_pkg::CAUSE_MARKER;
                  res_valid_in  = 1'b1;
               end else if (in_window) begin
                  if (accept_count_ff == drop_position_ff) begin
                     marker_in     = req_seq;
                     verdict_cause = rpdf_pkg::CAUSE_EMULATE;
                  end else begin
                     verdict_acc   = 1'b1;
                     verdict_cause = rpdf_pkg::CAUSE_WINDOW;
                  end
                  accept_count_in = accept_count_ff + 16'd1;
                  res_valid_in    = 1'b1;
               end else begin
                  launch = 1'b1;
               end
            end
         end
         rpdf_pkg::ST_SEARCH: begin
            if (tail_link.active) begin
               if (tail_link.hit) begin
                  window_in     = rpdf_pkg::WINDOW_W'(accept_count_ff)
                                  + rpdf_pkg::WINDOW_W'(drop_count_ff);
                  finished_in   = 1'b1;
                  verdict_acc   = 1'b1;
                  verdict_cause = rpdf_pkg::CAUSE_RETRANS;
               end else if (!table_full) begin
                  shift_en      = 1'b1;
                  drop_count_in = drop_count_ff + CNT_W'(1);
               end
               res_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
      res_data_in = {(drop_count_in == CNT_W'(TABLE_DEPTH)), window_in, finished_in,
                     verdict_cause, verdict_acc};
   end

   // configuration writes
   always_comb begin
      accept_limit_in  = accept_limit_ff;
      drop_position_in = drop_position_ff;
      if (csr_wen) begin
         case (csr_addr)
            rpdf_pkg::REG_ACCEPT_LIMIT:  accept_limit_in  = csr_wdata;
            rpdf_pkg::REG_DROP_POSITION: drop_position_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, res_data_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= rpdf_pkg::ST_IDLE;
         accept_limit_ff  <= rpdf_pkg::ACCEPT_LIMIT_RST;
         drop_position_ff <= rpdf_pkg::DROP_POSITION_RST;
         accept_count_ff  <= '0;
         marker_ff        <= '0;
         drop_count_ff    <= '0;
         finished_ff      <= 1'b0;
         window_ff        <= '0;
         res_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         accept_limit_ff  <= accept_limit_in;
         drop_position_ff <= drop_position_in;
         accept_count_ff  <= accept_count_in;
         marker_ff        <= marker_in;
         drop_count_ff    <= drop_count_in;
         finished_ff      <= finished_in;
         window_ff        <= window_in;
         res_valid_ff     <= res_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid_in && !(res_valid_ff && !res_move)) begin
         res_data_ff <= res_data_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_ALWAYS(a_drop_count_bound, drop_count_ff <= CNT_W'(TABLE_DEPTH),
      "drop count beyond table depth")
   `ASSERT_NEXT(a_finished_sticky, finished_ff, finished_ff, "finished flag cleared")
   `ASSERT_ALWAYS(a_tail_in_search, !tail_link.active || state_ff == rpdf_pkg::ST_SEARCH,
      "query left the cell row outside a search")
   `ASSERT_NEXT(a_launch_search, launch, state_ff == rpdf_pkg::ST_SEARCH,
      "table search launched without entering search")
   `ASSERT_ALWAYS(a_no_result_overwrite, !(res_valid_ff && !res_move && res_valid_in
      && state_ff == rpdf_pkg::ST_SEARCH && tail_link.active),
      "verdict written over a waiting result")

endmodule

/* hw/rtl/rpdf_cell.sv */
// One cell of the dropped-number row: holds one stored number and
// checks a passing query against it. Depends on rpdf_pkg.
module rpdf_cell #(
   parameter int CNT_W = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rpdf_pkg::link_type        prev_link,
   input  logic [CNT_W-1:0]          prev_rem,
   output rpdf_pkg::link_type        next_link,
   output logic [CNT_W-1:0]          next_rem,
   input  logic                      shift_en,
   input  logic [rpdf_pkg::SEQ_W-1:0] prev_entry,
   output logic [rpdf_pkg::SEQ_W-1:0] entry
);

   logic                       active_ff;
   logic                       hit_ff, hit_in;
   logic [rpdf_pkg::SEQ_W-1:0] seq_ff;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [rpdf_pkg::SEQ_W-1:0] entry_ff;

   // entry only counts while the query still has valid entries left
   assign hit_in = prev_link.hit | ((prev_rem != '0) && (entry_ff == prev_link.seq));
   assign rem_in = (prev_rem == '0) ? '0 : prev_rem - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= prev_link.active;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      seq_ff <= prev_link.seq;
      rem_ff <= rem_in;
      if (shift_en) begin
         entry_ff <= prev_entry;
      end
   end

   assign next_link.active = active_ff;
   assign next_link.hit    = hit_ff;
   assign next_link.seq    = seq_ff;
   assign next_rem         = rem_ff;
   assign entry            = entry_ff;

endmodule

/* hw/rtl/rpdf_chain.sv */
// Row of rpdf_cell instances forming the dropped-number table.
// New numbers enter at the head and push older ones along. Depends on rpdf_pkg.
module rpdf_chain #(
   parameter int DEPTH = 256,
   parameter int CNT_W = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rpdf_pkg::link_type         head_link,
   input  logic [CNT_W-1:0]           head_rem,
   input  logic                       shift_en,
   input  logic [rpdf_pkg::SEQ_W-1:0] head_entry,
   output rpdf_pkg::link_type         tail_link
);

   rpdf_pkg::link_type         link [DEPTH+1];
   logic [CNT_W-1:0]           rem  [DEPTH+1];
   logic [rpdf_pkg::SEQ_W-1:0] ent  [DEPTH+1];

   assign link[0] = head_link;
   assign rem[0]  = head_rem;
   assign ent[0]  = head_entry;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      rpdf_cell #(
         .CNT_W(CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_link  (link[k]),
         .prev_rem   (rem[k]),
         .next_link  (link[k+1]),
         .next_rem   (rem[k+1]),
         .shift_en   (shift_en),
         .prev_entry (ent[k]),
         .entry      (ent[k+1])
      );
   end

   assign tail_link = link[DEPTH];

endmodule

/* tb/sv/probe_verdict_checker.sv */
`timescale 1ns / 1ps
// Checker for the probe drop filter: watches the req_, rsp_ and csr_ ports,
// predicts each verdict word from its own filter state. Depends on rpdf_pkg.
module probe_verdict_checker #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [rpdf_pkg::REQ_W-1:0]     req_tdata,  // [31:0] seq_number
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] accept, [3:1] verdict_cause, [4] finished, [21:5] next_window,
   // [22] table_full, [23] zero
   input  logic [rpdf_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                           csr_wen,
   input  logic [rpdf_pkg::CSR_A_W-1:0]   csr_addr,
   input  logic [rpdf_pkg::CFG_W-1:0]     csr_wdata,
   output int                             failures,
   output int                             verdicts_seen,
   output int                             outstanding,
   output int                             tail_drops,
   output int                             retrans_hits,
   output logic                           table_filled,
   output logic [rpdf_pkg::CFG_W-1:0]     window_count
);

   typedef struct packed {
      logic                          reserved;
      logic                          table_full;
      logic [rpdf_pkg::WINDOW_W-1:0] next_window;
      logic                          finished;
      rpdf_pkg::cause_type           cause;
      logic                          accept;
   } verdict_type;

   logic [rpdf_pkg::CFG_W-1:0]    accept_limit;
   logic [rpdf_pkg::CFG_W-1:0]    drop_position;
   logic [rpdf_pkg::CFG_W-1:0]    accept_count;
   logic [rpdf_pkg::SEQ_W-1:0]    marker_seq;
   logic [rpdf_pkg::SEQ_W-1:0]    dropped_seqs[$];
   logic                          finished_flag;
   logic [rpdf_pkg::WINDOW_W-1:0] captured_window;
   verdict_type                   verdicts_due[$];

   assign window_count = accept_count;

   function automatic verdict_type judge_packet(input logic [rpdf_pkg::SEQ_W-1:0] seq);
      verdict_type v;
      bit          seen;
      v = '0;
      seen = 1'b0;
      foreach (dropped_seqs[k])
         if (dropped_seqs[k] == seq)
            seen = 1'b1;
      if (seq == marker_seq) begin
         v.accept = 1'b1;
         v.cause  = rpdf_pkg::CAUSE_MARKER;
      end else if (accept_count < accept_limit) begin
         if (accept_count == drop_position) begin
            marker_seq = seq;
            v.accept   = 1'b0;
            v.cause    = rpdf_pkg::CAUSE_EMULATE;
         end else begin
            v.accept = 1'b1;
            v.cause  = rpdf_pkg::CAUSE_WINDOW;
         end
         accept_count = accept_count + rpdf_pkg::CFG_W'(1);
      end else if (seen) begin
         captured_window = rpdf_pkg::WINDOW_W'(int'(accept_count) + dropped_seqs.size());
         finished_flag   = 1'b1;
         v.accept        = 1'b1;
         v.cause         = rpdf_pkg::CAUSE_RETRANS;
         retrans_hits    = retrans_hits + 1;
      end else begin
         if (dropped_seqs.size() < TABLE_DEPTH)
            dropped_seqs.push_back(seq);
         v.accept   = 1'b0;
         v.cause    = rpdf_pkg::CAUSE_TAIL;
         tail_drops = tail_drops + 1;
      end
      v.finished    = finished_flag;
      v.next_window = captured_window;
      v.table_full  = (dropped_seqs.size() >= TABLE_DEPTH);
      if (v.table_full)
         table_filled = 1'b1;
      return v;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("verdict field %s: expected %0d, got %0d", name, want, got);
         failures = failures + 1;
      end
   endtask

   always @(posedge clock) begin : watch
      verdict_type want;
      verdict_type got;
      if (reset) begin
         accept_limit    = rpdf_pkg::ACCEPT_LIMIT_RST;
         drop_position   = rpdf_pkg::DROP_POSITION_RST;
         accept_count    = '0;
         marker_seq      = '0;
         finished_flag   = 1'b0;
         captured_window = '0;
         table_filled    = 1'b0;
         failures        = 0;
         tail_drops      = 0;
         retrans_hits    = 0;
         dropped_seqs.delete();
         verdicts_due.delete();
         verdicts_seen <= 0;
         outstanding   <= 0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               rpdf_pkg::REG_ACCEPT_LIMIT:  accept_limit  = csr_wdata;
               rpdf_pkg::REG_DROP_POSITION: drop_position = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            verdicts_due.push_back(judge_packet(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            verdicts_seen <= verdicts_seen + 1;
            got = rsp_tdata;
            if (verdicts_due.size() == 0) begin
               $error("verdict word %h arrived with no packet waiting", rsp_tdata);
               failures = failures + 1;
            end else begin
               want = verdicts_due.pop_front();
               check_field("accept", want.accept, got.accept);
               check_field("verdict_cause", want.cause, got.cause);
               check_field("finished", want.finished, got.finished);
               check_field("next_window", want.next_window, got.next_window);
               check_field("table_full", want.table_full, got.table_full);
               check_field("reserved", want.reserved, got.reserved);
            end
         end
         outstanding <= verdicts_due.size();
      end
   end

endmodule

/* tb/sv/retrans_probe_drop_filter_tb.sv */
`timescale 1ns / 1ps
// Top of the probe drop filter testbench: clock, reset, packet and register
// stimulus, verdict. Depends on rpdf_pkg, probe_verdict_checker and the RTL.
module retrans_probe_drop_filter_tb;

   localparam int TABLE_DEPTH   = 256;
   localparam int PACKET_TARGET = 1050;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam logic [rpdf_pkg::CSR_A_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [rpdf_pkg::CSR_A_W-1:0] REG_SPARE_HI = 2'd3;
   localparam logic [rpdf_pkg::SEQ_W-1:0]   PROBE_SEQ    = 32'hA5A5_0001;
   localparam logic [rpdf_pkg::SEQ_W-1:0]   LOST_SEQ     = 32'h1234_5678;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [rpdf_pkg::REQ_W-1:0]    req_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [rpdf_pkg::RSP_W-1:0]    rsp_tdata;
   logic                          csr_wen;
   logic [rpdf_pkg::CSR_A_W-1:0]  csr_addr;
   logic [rpdf_pkg::CFG_W-1:0]    csr_wdata;

   int                            failures;
   int                            verdicts_seen;
   int                            outstanding;
   int                            tail_drops;
   int                            retrans_hits;
   logic                          table_filled;
   logic [rpdf_pkg::CFG_W-1:0]    window_count;

   int                            sent_total  = 0;
   int                            phase_total = 0;
   int                            cycle_count = 0;
   bit                            hold_off_go = 1'b0;
   bit                            calm_send   = 1'b0;
   logic [rpdf_pkg::SEQ_W-1:0]    seq_pool[$];

   retrans_probe_drop_filter #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   probe_verdict_checker #(.TABLE_DEPTH(TABLE_DEPTH)) verdict_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wen       (csr_wen),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .failures      (failures),
      .verdicts_seen (verdicts_seen),
      .outstanding   (outstanding),
      .tail_drops    (tail_drops),
      .retrans_hits  (retrans_hits),
      .table_filled  (table_filled),
      .window_count  (window_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("retrans_probe_drop_filter_tb: errors");
         $finish;
      end
   end

   // one packet word; the gap before it is random unless the phase is calm
   task automatic send_seq(input logic [rpdf_pkg::SEQ_W-1:0] seq);
      int gap;
      int roll;
      roll = $urandom_range(0, 19);
      if (calm_send || roll < 10)
         gap = 0;
      else if (roll < 18)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= seq;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_total = sent_total + 1;
      seq_pool.push_back(seq);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (verdicts_seen != sent_total) @(posedge clock);
   endtask

   // leaves csr_wen high; the caller lowers it after the last write
   task automatic write_reg(input logic [rpdf_pkg::CSR_A_W-1:0] idx,
                            input logic [rpdf_pkg::CFG_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // receiver: short and long stalls, calm stretches, one long hold-off
   initial begin : receiver
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left  = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_go = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(0, 299) == 0)
               calm_left = $urandom_range(50, 300);
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
               if (calm_left == 0 && $urandom_range(0, 3) == 0)
                  stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                           : $urandom_range(1, 3);
            end
         end
      end
   end

   initial begin : stimulus
      int kind;
      int span;
      int count_now;
      int limit;
      int pos;
      int n;
      int roll;
      logic [rpdf_pkg::SEQ_W-1:0] seq;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_wen    <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // marker still zero after reset
      send_seq('0);
      wait_idle();

      // emulated drop at the very first counted packet, short window
      write_reg(rpdf_pkg::REG_DROP_POSITION, 16'd0);
      write_reg(rpdf_pkg::REG_ACCEPT_LIMIT, 16'd6);
      csr_wen <= 1'b0;
      phase_total++;
      send_seq(PROBE_SEQ);
      send_seq(PROBE_SEQ);
      send_seq('0);
      send_seq('1);
      send_seq(32'h0000_0001);
      send_seq(32'h8000_0000);
      send_seq(32'h5555_AAAA);
      // tail drops, then repeated retransmissions and the marker again
      send_seq(LOST_SEQ);
      send_seq('1);
      send_seq(LOST_SEQ);
      send_seq(LOST_SEQ);
      send_seq(PROBE_SEQ);
      send_seq('0);
      send_seq('1);
      wait_idle();

      // zero window; spare indexes must change nothing
      write_reg(rpdf_pkg::REG_ACCEPT_LIMIT, 16'd0);
      write_reg(REG_SPARE_LO, 16'hFFFF);
      write_reg(REG_SPARE_HI, 16'h0000);
      csr_wen <= 1'b0;
      phase_total++;
      send_seq(32'hAAAA_5555);
      send_seq(32'h7FFF_FFFE);
      wait_idle();

      // widest window, drop position out of reach
      write_reg(rpdf_pkg::REG_ACCEPT_LIMIT, 16'hFFFF);
      write_reg(rpdf_pkg::REG_DROP_POSITION, 16'hFFFF);
      csr_wen <= 1'b0;
      phase_total++;
      send_seq('0);
      send_seq($urandom);
      send_seq($urandom);
      send_seq(32'hFFFF_0000);
      wait_idle();

      while (sent_total < PACKET_TARGET) begin
         count_now = window_count;
         kind = (phase_total == 3) ? 0 : $urandom_range(0, 4);
         case (kind)
            0: begin
               span  = $urandom_range(5, 30);
               limit = (count_now + span > 65535) ? 65535 : count_now + span;
               pos   = count_now + $urandom_range(0, span - 1);
            end
            1: begin
               span  = $urandom_range(3, 30);
               limit = (count_now + span > 65535) ? 65535 : count_now + span;
               pos   = (limit + 3 > 65535) ? 65535 : limit + $urandom_range(0, 3);
            end
            2: begin
               limit = $urandom_range(0, count_now);
               pos   = $urandom_range(0, 65535);
            end
            3: begin
               limit = $urandom_range(0, 1) ? 65535 : 0;
               pos   = $urandom_range(0, 1) ? 65535 : 0;
            end
            default: begin
               limit = $urandom_range(0, 65535);
               pos   = $urandom_range(0, 65535);
            end
         endcase
         if ($urandom_range(0, 1)) begin
            write_reg(rpdf_pkg::REG_ACCEPT_LIMIT, rpdf_pkg::CFG_W'(limit));
            write_reg(rpdf_pkg::REG_DROP_POSITION, rpdf_pkg::CFG_W'(pos));
         end else begin
            write_reg(rpdf_pkg::REG_DROP_POSITION, rpdf_pkg::CFG_W'(pos));
            write_reg(rpdf_pkg::REG_ACCEPT_LIMIT, rpdf_pkg::CFG_W'(limit));
         end
         if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      rpdf_pkg::CFG_W'($urandom));
         csr_wen <= 1'b0;
         phase_total++;
         calm_send = ($urandom_range(0, 3) == 0);
         // block fills up behind a stalled receiver in the first random phase
         if (kind == 0 && phase_total == 4)
            hold_off_go = 1'b1;

         n = $urandom_range(15, 60);
         if (n > PACKET_TARGET - sent_total)
            n = PACKET_TARGET - sent_total;
         repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
               seq = seq_pool[$urandom_range(0, seq_pool.size() - 1)];
            else if (roll < 42)
               seq = 32'h1 << $urandom_range(0, 31);
            else if (roll < 48)
               seq = ~(32'h1 << $urandom_range(0, 31));
            else if (roll < 52)
               seq = $urandom_range(0, 1) ? '0 : '1;
            else
               seq = $urandom;
            send_seq(seq);
         end
         wait_idle();
      end

      calm_send = 1'b0;
      repeat (TABLE_DEPTH + 16) @(posedge clock);

      $display("summary: %0d packets over %0d register settings in %0d cycles",
               sent_total, phase_total, cycle_count);
      $display("summary: %0d tail drops, %0d retransmissions caught, table filled %0d",
               tail_drops, retrans_hits, table_filled);
      if (failures == 0 && outstanding == 0)
         $display("retrans_probe_drop_filter_tb: clean");
      else
         $display("retrans_probe_drop_filter_tb: errors");
      $finish;
   end

endmodule

/* retrans_probe_drop_filter.f */
+incdir+hw/rtl
hw/rtl/rpdf_pkg.sv
hw/rtl/rpdf_cell.sv
hw/rtl/rpdf_chain.sv
hw/rtl/retrans_probe_drop_filter.sv
tb/sv/probe_verdict_checker.sv
tb/sv/retrans_probe_drop_filter_tb.sv
